@@ src/u8bmp_pkg.sv @@
package u8bmp_pkg;

    localparam int ByteW = 8;
    localparam int CodeW = 16;
    localparam int PartW = 10;

    localparam logic [ByteW-1:0] AsciiLimit  = 8'h80;
    localparam logic [ByteW-1:0] Lead2Low    = 8'hc2;
    localparam logic [ByteW-1:0] Lead3Low    = 8'he0;
    localparam logic [ByteW-1:0] Lead4Low    = 8'hf0;
    localparam logic [ByteW-1:0] ContLow     = 8'h80;
    localparam logic [ByteW-1:0] ContHigh    = 8'hbf;
    localparam logic [ByteW-1:0] E0SecondLow = 8'ha0;

    // decoder phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE         = 4'b0001,
        PH_TWO_LAST     = 4'b0010,
        PH_THREE_SECOND = 4'b0100,
        PH_THREE_LAST   = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [PartW-1:0]   partial;
        logic               lead_e0;
    } dec_state_t;

    typedef struct packed {
        dec_state_t         state;
        logic               emit;
        logic [CodeW-1:0]   code_point;
    } dec_step_t;

endpackage

@@ src/utf8_bmp_stream_decoder.sv @@
// UTF-8 to 16-bit code point decoder (Basic Multilingual Plane).
// Input channel s_*: one raw byte per beat on s_tdata[7:0].
// Output channel m_*: one code point per beat on m_tdata[15:0].
// A byte may produce no beat (stray or unsupported bytes, first bytes of
// a multi-byte sequence) or exactly one beat; 0 marks end of string.
// A code point appears on m_* in the cycle after its last byte is
// accepted. Throughput: one byte per cycle unless m_* stalls; state_reg
// and the output register are stored; next state is one short decode.
// A bad continuation byte drops the open sequence and is decoded again as
// a fresh start in the same cycle, so errors do not slow the input.
// Reset (aresetn low, synchronous) closes any open sequence and empties
// the output register.
// Stall: when m_tready is low with a beat pending, s_tready follows low;
// a byte is still taken in the cycle the pending beat drains.
module utf8_bmp_stream_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [u8bmp_pkg::ByteW-1:0]   s_tdata,   // [7:0] byte_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u8bmp_pkg::CodeW-1:0]   m_tdata    // [15:0] code_point
);

    u8bmp_pkg::dec_state_t            state_reg, state_next;
    u8bmp_pkg::dec_step_t             step;
    logic                             out_valid_reg, out_valid_next;
    logic [u8bmp_pkg::CodeW-1:0]      out_data_reg, out_data_next;
    logic                             s_beat;

    // decode of the incoming byte against the current sequence state
    u8bmp_step u_step (
        .byte_in (s_tdata),
        .cur     (state_reg),
        .step    (step)
    );

    // take a byte whenever the output register is empty or draining
    assign s_tready = !out_valid_reg || m_tready;
    assign s_beat   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (s_beat) begin
            state_next     = step.state;
            out_valid_next = step.emit;
            out_data_next  = step.code_point;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase   <= u8bmp_pkg::PH_IDLE;
            state_reg.partial <= '0;
            state_reg.lead_e0 <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ src/u8bmp_step.sv @@
module u8bmp_step (
    input  logic [u8bmp_pkg::ByteW-1:0] byte_in,
    input  u8bmp_pkg::dec_state_t       cur,
    output u8bmp_pkg::dec_step_t        step
);

    u8bmp_pkg::dec_step_t start;
    logic                 is_cont;
    logic                 second_ok;

    assign is_cont   = (byte_in >= u8bmp_pkg::ContLow) && (byte_in <= u8bmp_pkg::ContHigh);
    // after an E0 lead the second byte must be A0..BF (no overlong forms)
    assign second_ok = (byte_in <= u8bmp_pkg::ContHigh) &&
                       ((byte_in >= u8bmp_pkg::E0SecondLow) ||
                        ((byte_in >= u8bmp_pkg::ContLow) && !cur.lead_e0));

    // byte handled with no sequence open
    always_comb begin
        start.state.phase   = u8bmp_pkg::PH_IDLE;
        start.state.partial = cur.partial;
        start.state.lead_e0 = cur.lead_e0;
        start.emit          = 1'b0;
        start.code_point    = {{(u8bmp_pkg::CodeW-u8bmp_pkg::ByteW){1'b0}}, byte_in};
        if (byte_in < u8bmp_pkg::AsciiLimit) begin
            start.emit = 1'b1;
        end else if (byte_in < u8bmp_pkg::Lead2Low) begin
            start.emit = 1'b0;
        end else if (byte_in < u8bmp_pkg::Lead3Low) begin
            start.state.partial = {5'b0, byte_in[4:0]};
            start.state.phase   = u8bmp_pkg::PH_TWO_LAST;
        end else if (byte_in < u8bmp_pkg::Lead4Low) begin
            start.state.partial = {6'b0, byte_in[3:0]};
            start.state.lead_e0 = (byte_in == u8bmp_pkg::Lead3Low);
            start.state.phase   = u8bmp_pkg::PH_THREE_SECOND;
        end
    end

    always_comb begin
        step = start;
        case (cur.phase)
            u8bmp_pkg::PH_TWO_LAST: begin
                if (is_cont) begin
                    step.state      = cur;
                    step.state.phase = u8bmp_pkg::PH_IDLE;
                    step.emit       = 1'b1;
                    step.code_point = {5'b0, cur.partial[4:0], byte_in[5:0]};
                end
            end
            u8bmp_pkg::PH_THREE_SECOND: begin
                if (second_ok) begin
                    step.state         = cur;
                    step.state.phase   = u8bmp_pkg::PH_THREE_LAST;
                    step.state.partial = {cur.partial[3:0], byte_in[5:0]};
                    step.emit          = 1'b0;
                end
            end
            u8bmp_pkg::PH_THREE_LAST: begin
                if (is_cont) begin
                    step.state       = cur;
                    step.state.phase = u8bmp_pkg::PH_IDLE;
                    step.emit        = 1'b1;
                    step.code_point  = {cur.partial, byte_in[5:0]};
                end
            end
            default: begin
                step = start;
            end
        endcase
    end

endmodule

@@ tb/tb_utf8_bmp_stream_decoder.sv @@
`timescale 1ns / 100ps

module tb_utf8_bmp_stream_decoder;

    // Watchdog: cycles with no beat on either side before the run is abandoned.
    // The longest legal gap is the receiver hold-off (HoldCycles) plus idling.
    localparam int HoldCycles   = 300;
    localparam int QuietLimit   = 4000;
    localparam int MaxShownErrs = 10;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [u8bmp_pkg::ByteW-1:0]    s_tdata  = '0;    // [7:0] byte_in
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [u8bmp_pkg::CodeW-1:0]    m_tdata;          // [15:0] code_point

    // Idle percentage for both sides; the test flow changes it with NBAs so
    // the receiver picks it up cleanly at the next edge.
    int unsigned        idle_pct   = 24;
    // Toggled by the test flow to ask the receiver for one long hold-off.
    logic               hold_tog   = 1'b0;
    logic               hold_seen  = 1'b0;
    int unsigned        hold_left  = 0;

    // Predictor state: own copy of the decoder's phase and gathered payload.
    u8bmp_pkg::phase_t              dec_phase  = u8bmp_pkg::PH_IDLE;
    logic [u8bmp_pkg::PartW-1:0]    dec_part   = '0;
    logic                           dec_e0     = 1'b0;

    logic [u8bmp_pkg::CodeW-1:0]    cp_expect_q[$];

    int                 n_err      = 0;
    int                 n_bytes    = 0;
    int                 n_points   = 0;
    int                 quiet_cyc  = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    utf8_bmp_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Next-state and output of the decoder for one byte. Returns 1 when the
    // byte completes a code point (written to cp).
    function automatic bit decode_byte(input logic [u8bmp_pkg::ByteW-1:0] b,
                                       output logic [u8bmp_pkg::CodeW-1:0] cp);
        bit is_cont;
        is_cont = (b >= u8bmp_pkg::ContLow) && (b <= u8bmp_pkg::ContHigh);
        cp = '0;
        case (dec_phase)
            u8bmp_pkg::PH_TWO_LAST: begin
                if (is_cont) begin
                    cp = {5'b0, dec_part[4:0], b[5:0]};
                    dec_phase = u8bmp_pkg::PH_IDLE;
                    return 1'b1;
                end
            end
            u8bmp_pkg::PH_THREE_SECOND: begin
                // after E0 only A0..BF may follow (overlong guard)
                if (b <= u8bmp_pkg::ContHigh &&
                    (b >= u8bmp_pkg::E0SecondLow || (is_cont && !dec_e0))) begin
                    dec_part = {dec_part[3:0], b[5:0]};
                    dec_phase = u8bmp_pkg::PH_THREE_LAST;
                    return 1'b0;
                end
            end
            u8bmp_pkg::PH_THREE_LAST: begin
                if (is_cont) begin
                    cp = {dec_part, b[5:0]};
                    dec_phase = u8bmp_pkg::PH_IDLE;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        // idle, or a bad continuation: decode the byte as a fresh start
        dec_phase = u8bmp_pkg::PH_IDLE;
        if (b < u8bmp_pkg::AsciiLimit) begin
            cp = {8'h00, b};
            return 1'b1;
        end
        if (b < u8bmp_pkg::Lead2Low)
            return 1'b0;
        if (b < u8bmp_pkg::Lead3Low) begin
            dec_part  = {5'b0, b[4:0]};
            dec_phase = u8bmp_pkg::PH_TWO_LAST;
            return 1'b0;
        end
        if (b < u8bmp_pkg::Lead4Low) begin
            dec_part  = {6'b0, b[3:0]};
            dec_e0    = (b == u8bmp_pkg::Lead3Low);
            dec_phase = u8bmp_pkg::PH_THREE_SECOND;
            return 1'b0;
        end
        return 1'b0;   // F0..FF: skipped, nothing opened
    endfunction

    // Offer one byte, with random idle cycles ahead of it, and hold it until
    // accepted. Called and returns at a rising edge; tvalid stays high after
    // acceptance so back-to-back beats need no gap.
    task automatic send_byte(input logic [u8bmp_pkg::ByteW-1:0] b);
        logic [u8bmp_pkg::CodeW-1:0] cp;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        n_bytes++;
        if (decode_byte(b, cp))
            cp_expect_q.push_back(cp);
    endtask

    // Sender goes quiet until every predicted code point has come out.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (cp_expect_q.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // One chunk of text: mostly well-formed sequences with random payload,
    // some raw noise bytes and some broken sequences.
    task automatic send_text_unit();
        int unsigned                  kind;
        logic [u8bmp_pkg::ByteW-1:0]  lead;
        kind = $urandom_range(99);
        if (kind < 30) begin
            send_byte(8'($urandom_range(8'h7f, 8'h01)));
        end else if (kind < 33) begin
            send_byte(8'h00);
        end else if (kind < 55) begin
            send_byte(8'($urandom_range(8'hdf, 8'hc2)));
            send_byte(8'($urandom_range(8'hbf, 8'h80)));
        end else if (kind < 80) begin
            lead = 8'($urandom_range(8'hef, 8'he0));
            send_byte(lead);
            if (lead == u8bmp_pkg::Lead3Low)
                send_byte(8'($urandom_range(8'hbf, 8'ha0)));
            else
                send_byte(8'($urandom_range(8'hbf, 8'h80)));
            send_byte(8'($urandom_range(8'hbf, 8'h80)));
        end else if (kind < 90) begin
            // often broken: a lead, maybe a continuation byte, then any byte
            send_byte(8'($urandom_range(8'hef, 8'hc2)));
            if ($urandom_range(1))
                send_byte(8'($urandom_range(8'hbf, 8'h80)));
            send_byte(8'($urandom_range(255)));
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_ascii_and_nul();
        send_byte(8'h00);
        send_byte(8'h7f);
        wait_for_results();
    endtask

    task automatic test_two_byte();
        send_byte(8'hc2); send_byte(8'h80);
        send_byte(8'hdf); send_byte(8'hbf);
        wait_for_results();
    endtask

    task automatic test_three_byte();
        send_byte(8'he0); send_byte(8'ha0); send_byte(8'h80);   // lowest non-overlong
        send_byte(8'hef); send_byte(8'hbf); send_byte(8'hbf);   // FFFF
        send_byte(8'hed); send_byte(8'ha0); send_byte(8'h80);   // surrogate passes
        wait_for_results();
    endtask

    task automatic test_stray_and_bad_lead();
        send_byte(8'h80);    // stray continuation
        send_byte(8'hc1);    // overlong two-byte lead
        send_byte(8'hf0);    // four-byte lead, skipped
        send_byte(8'hff);
        wait_for_results();
    endtask

    task automatic test_bad_continuation();
        send_byte(8'hc2); send_byte(8'h41);                     // drop, emit 'A'
        send_byte(8'he0); send_byte(8'h9f);                     // overlong, 9F is stray
        send_byte(8'he1); send_byte(8'hc3); send_byte(8'ha9);   // restart as two-byte
        send_byte(8'hc2); send_byte(8'h00);                     // NUL drops partial
        wait_for_results();
    endtask

    task automatic test_random_text();
        int start;
        start = n_bytes;
        while (n_bytes - start < 580)
            send_text_unit();
        wait_for_results();
    endtask

    // Receiver holds off while the sender keeps offering: the output register
    // fills and s_tready must drop until the hold ends.
    task automatic test_backpressure();
        int start;
        hold_tog <= ~hold_tog;
        start = n_bytes;
        while (n_bytes - start < 60)
            send_text_unit();
        wait_for_results();
    endtask

    task automatic test_full_rate();
        int start;
        idle_pct <= 0;
        start = n_bytes;
        while (n_bytes - start < 120)
            send_text_unit();
        wait_for_results();
        idle_pct <= 24;
    endtask

    // Receiver: random tready, or a counted hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= HoldCycles;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Result checker: every output beat against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_points++;
            if (cp_expect_q.size() == 0) begin
                if (n_err < MaxShownErrs)
                    $display("ERROR: unexpected code point %h", m_tdata);
                n_err++;
            end else begin
                if (m_tdata !== cp_expect_q[0]) begin
                    if (n_err < MaxShownErrs)
                        $display("ERROR: code point exp %h got %h", cp_expect_q[0], m_tdata);
                    n_err++;
                end
                void'(cp_expect_q.pop_front());
            end
        end
    end

    // Watchdog on cycles without any beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= QuietLimit) begin
            $display("timeout: no beat for %0d cycles", quiet_cyc);
            $display("tb_utf8_bmp_stream_decoder: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ascii_and_nul();
        test_two_byte();
        test_three_byte();
        test_stray_and_bad_lead();
        test_bad_continuation();
        test_random_text();
        test_backpressure();
        test_full_rate();

        if (cp_expect_q.size() != 0) begin
            $display("ERROR: %0d code points never came out", cp_expect_q.size());
            n_err++;
        end
        $display("covered %0d bytes in, %0d code points out: 1/2/3-byte forms, NUL, strays,",
                 n_bytes, n_points);
        $display("broken sequences, a %0d-cycle output hold-off and a full-rate stretch",
                 HoldCycles);
        if (n_err == 0)
            $display("tb_utf8_bmp_stream_decoder: done, clean");
        else
            $display("tb_utf8_bmp_stream_decoder: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
src/u8bmp_pkg.sv
src/u8bmp_step.sv
src/utf8_bmp_stream_decoder.sv
tb/tb_utf8_bmp_stream_decoder.sv
